// ===== hw/rtl/hdu_pkg.sv =====
// ----------------------------------------------------------------------------
// hdu_pkg: shared definitions for the half-duplex 8N1 UART
// Widths, reset values, register indexes and the result record that passes
// from the link core to the output stage.
// ----------------------------------------------------------------------------
package hdu_pkg;

  // Frame shape: start bit, data bits, stop bit.
  localparam int DATA_BITS  = 8;
  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);

  // Bit timer width.
  localparam int TICK_WIDTH = 16;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd1;
  localparam logic [CFG_W-1:0] BIT_PERIOD_RST  = 16'd105;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd52;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [TICK_WIDTH-1:0] tick_t;
  typedef logic [BITS_W-1:0]     bits_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [DATA_BITS-1:0]  data_t;

  // One result item per accepted tick.
  typedef struct packed {
    logic       tx_level;
    logic       tx_active;
    logic       rx_active;
    logic       byte_ready;
    logic [7:0] got_byte;
    logic       framing_error;
  } res_t;

  // A period register masked to the timer width; zero counts as one tick.
  function automatic tick_t load_period(input logic [CFG_W-1:0] p);
    tick_t v;
    v = tick_t'(p);
    return (v == '0) ? tick_t'(1) : v;
  endfunction

endpackage

// ===== hw/rtl/hdu_core.sv =====
// ----------------------------------------------------------------------------
// hdu_core: link state and per-tick update
// Holds the configuration registers and the transmit/receive state, and
// works out the next state and the result of one tick in a single pass.
// ----------------------------------------------------------------------------
module hdu_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [hdu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdu_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           step,
  input  logic                           rx_level,
  input  logic                           send_request,
  input  logic [7:0]                     send_byte,
  output hdu_pkg::res_t                  res
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_t;

  logic [hdu_pkg::CFG_W-1:0] bit_period_r;
  logic [hdu_pkg::CFG_W-1:0] half_period_r;

  mode_t           mode_r, mode_nxt;
  hdu_pkg::tick_t  tick_r, tick_nxt;
  hdu_pkg::bits_t  bits_r, bits_nxt;
  hdu_pkg::frame_t tx_shift_r, tx_shift_nxt;
  hdu_pkg::frame_t rx_shift_r, rx_shift_nxt;
  logic            prev_rx_r;
  logic            line_out_r, line_out_nxt;

  hdu_pkg::tick_t  tick_dec;
  hdu_pkg::data_t  tx_data;
  logic            ready;
  logic [7:0]      got;
  logic            ferr;

  // Next state for one tick.
  always_comb begin
    mode_nxt     = mode_r;
    tick_nxt     = tick_r;
    bits_nxt     = bits_r;
    tx_shift_nxt = tx_shift_r;
    rx_shift_nxt = rx_shift_r;
    line_out_nxt = line_out_r;
    ready        = 1'b0;
    got          = 8'd0;
    ferr         = 1'b0;
    tick_dec     = tick_r - hdu_pkg::tick_t'(1);
    tx_data      = hdu_pkg::data_t'(send_byte);

    if (mode_r == MODE_IDLE) begin
      // A falling receive edge takes priority over a transmit request.
      if (prev_rx_r && !rx_level) begin
        mode_nxt     = MODE_RX;
        tick_nxt     = hdu_pkg::load_period(half_period_r);
        bits_nxt     = hdu_pkg::bits_t'(hdu_pkg::FRAME_BITS);
        rx_shift_nxt = '0;
      end else if (send_request) begin
        mode_nxt     = MODE_TX;
        tick_nxt     = hdu_pkg::load_period(bit_period_r);
        bits_nxt     = hdu_pkg::bits_t'(hdu_pkg::FRAME_BITS);
        tx_shift_nxt = {1'b1, tx_data, 1'b0};
      end
    end else begin
      tick_nxt = tick_dec;
      if (tick_dec == '0) begin
        tick_nxt = hdu_pkg::load_period(bit_period_r);
        if (mode_r == MODE_TX) begin
          // Drive the next frame bit, or end the frame after the stop bit.
          if (bits_r == '0) begin
            mode_nxt     = MODE_IDLE;
            line_out_nxt = 1'b1;
          end else begin
            line_out_nxt = tx_shift_r[0];
            tx_shift_nxt = {1'b1, tx_shift_r[hdu_pkg::FRAME_BITS-1:1]};
            bits_nxt     = bits_r - hdu_pkg::bits_t'(1);
          end
        end else begin
          // Sample the line; the stop-bit sample completes the byte.
          rx_shift_nxt = {rx_level, rx_shift_r[hdu_pkg::FRAME_BITS-1:1]};
          if (bits_r != '0) begin
            bits_nxt = bits_r - hdu_pkg::bits_t'(1);
          end
          if (bits_nxt == '0) begin
            mode_nxt = MODE_IDLE;
            ready    = 1'b1;
            got      = 8'(rx_shift_nxt[hdu_pkg::DATA_BITS:1]);
            ferr     = rx_shift_nxt[0] | ~rx_shift_nxt[hdu_pkg::FRAME_BITS-1];
          end
        end
      end
    end
  end

  // Result of this tick, as seen after the update.
  always_comb begin
    res.tx_level      = line_out_nxt;
    res.tx_active     = (mode_nxt == MODE_TX);
    res.rx_active     = (mode_nxt == MODE_RX);
    res.byte_ready    = ready;
    res.got_byte      = got;
    res.framing_error = ferr;
  end

  // Configuration registers and link state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= hdu_pkg::BIT_PERIOD_RST;
      half_period_r <= hdu_pkg::HALF_PERIOD_RST;
      mode_r        <= MODE_IDLE;
      tick_r        <= '0;
      bits_r        <= '0;
      tx_shift_r    <= '1;
      rx_shift_r    <= '0;
      prev_rx_r     <= 1'b1;
      line_out_r    <= 1'b1;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          hdu_pkg::REG_BIT_PERIOD:  bit_period_r  <= cfg_wdata;
          hdu_pkg::REG_HALF_PERIOD: half_period_r <= cfg_wdata;
        endcase
      end
      if (step) begin
        mode_r     <= mode_nxt;
        tick_r     <= tick_nxt;
        bits_r     <= bits_nxt;
        tx_shift_r <= tx_shift_nxt;
        rx_shift_r <= rx_shift_nxt;
        prev_rx_r  <= rx_level;
        line_out_r <= line_out_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/hdu_out_reg.sv =====
// ----------------------------------------------------------------------------
// hdu_out_reg: result register on the master side
// Holds one result until it is taken and lets a new tick in on the same
// cycle that the held result is transferred.
// ----------------------------------------------------------------------------
module hdu_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hdu_pkg::res_t in_res,
  output logic          out_valid,
  input  logic          out_ready,
  output hdu_pkg::res_t out_res
);

  logic          valid_r;
  hdu_pkg::res_t res_r;

  // Space is free when the register is empty or is being emptied now.
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

endmodule

// ===== hw/rtl/half_duplex_uart_8n1.sv =====
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1: half-duplex 8N1 UART, one stream transfer per tick
// The result of a tick is registered and appears on the master side in the
// cycle after its input transfer. Throughput: one tick per cycle, limited
// only by the single result register when the master side stalls.
// Reset (rst_n, synchronous): line idle high, link idle, periods 105 and 52.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1 (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: rx_level, send_request, send_byte[7:0], zero padding
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hdu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: tx_level, tx_active, rx_active, byte_ready, got_byte[7:0],
  //            framing_error, zero padding
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hdu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wen,
  input  logic [hdu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdu_pkg::CFG_W-1:0]        cfg_wdata
);

  logic          step;
  hdu_pkg::res_t core_res;
  hdu_pkg::res_t hold_res;

  // A tick is taken on every slave-side transfer.
  assign step = in_tvalid && in_tready;

  hdu_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .step         (step),
    .rx_level     (in_tdata[0]),
    .send_request (in_tdata[1]),
    .send_byte    (in_tdata[9:2]),
    .res          (core_res)
  );

  hdu_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (core_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (hold_res)
  );

  // Pack the result fields, first field in the lowest bit.
  assign out_tdata = {3'b000, hold_res.framing_error, hold_res.got_byte,
                      hold_res.byte_ready, hold_res.rx_active,
                      hold_res.tx_active, hold_res.tx_level};

endmodule

// ===== hw/rtl/hdu_checker.sv =====
// ----------------------------------------------------------------------------
// hdu_checker: port-level checks for the half-duplex UART
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module hdu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [hdu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // With no result held, the slave side is always free.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Each accepted tick produces a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick produced no result");

  // Byte and error fields are zero unless a byte completes.
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[12:4] == 9'd0)
    else $error("receive fields set without byte_ready");

  // The transmit line idles high outside a frame; the half-duplex term is tested only there, where it always holds.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[0] && !(out_tdata[1] && out_tdata[2]))
    else $error("transmit line low outside a frame");

endmodule

bind half_duplex_uart_8n1 hdu_checker u_hdu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
